/* hw/rtl/itp_pkg.sv */
package itp_pkg;

   localparam logic [2:0] FUNC_OPERAND  = 3'd0;
   localparam logic [2:0] FUNC_OPERATOR = 3'd1;
   localparam logic [2:0] FUNC_OPEN     = 3'd2;
   localparam logic [2:0] FUNC_CLOSE    = 3'd3;
   localparam logic [2:0] FUNC_END      = 3'd4;

   localparam logic [2:0] OP_POW    = 3'd0;
   localparam logic [2:0] OP_MUL    = 3'd1;
   localparam logic [2:0] OP_DIV    = 3'd2;
   localparam logic [2:0] OP_MOD    = 3'd3;
   localparam logic [2:0] OP_ADD    = 3'd4;
   localparam logic [2:0] OP_SUB    = 3'd5;
   localparam logic [2:0] OP_MARKER = 3'd6;

   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_END      = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OPER,
      ST_CLOSE,
      ST_END
   } state_type;

   function automatic logic [1:0] op_prec(input logic [2:0] code);
      logic [1:0] prec;
      case (code)
         OP_POW: prec = 2'd3;
         OP_MUL, OP_DIV, OP_MOD: prec = 2'd2;
         OP_ADD, OP_SUB: prec = 2'd1;
         default: prec = 2'd0;
      endcase
      return prec;
   endfunction

endpackage

/* hw/rtl/itp_if.sv */
interface itp_req_if #(
   parameter int OPERAND_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic [2:0]              func;
   logic [2:0]              op_code;
   logic [OPERAND_BITS-1:0] operand_value;

   modport source (output valid, output func, output op_code, output operand_value,
                   input ready);
   modport sink (input valid, input func, input op_code, input operand_value,
                 output ready);
endinterface

interface itp_rsp_if #(
   parameter int OPERAND_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              out_kind;
   logic [2:0]              out_op;
   logic [OPERAND_BITS-1:0] out_value;
   logic                    overflowed;
   logic                    last;

   modport source (output valid, output out_kind, output out_op, output out_value,
                   output overflowed, output last, input ready);
   modport sink (input valid, input out_kind, input out_op, input out_value,
                 input overflowed, input last, output ready);
endinterface

/* hw/rtl/itp_ram.sv */
module itp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hw/rtl/infix_to_postfix_converter.sv */
// Infix to postfix converter (shunting-yard), one token per req word.
//
// req_chan carries one token: func gives its kind, op_code the operator,
// operand_value the operand. rsp_chan carries postfix words; last marks the
// final word caused by a token, and the end-of-expression word carries the
// sticky overflowed flag. Both channels move a word when valid and ready are
// high at a rising clock edge.
//
// The operator stack lives in a single-port-read RAM with a registered
// read. An operand leaves through the output register in the cycle after
// it is taken, one token per cycle while the output register is free. An
// open parenthesis is pushed from idle. Operator, close parenthesis and
// end tokens each pop one entry at a time in their own state, end then
// emitting the end word. The RAM read of the next stack top paces each pop.
//
// Reset clears the state, the stack count, the discard, overflow and
// pending flags and the output valid flag; stack entries need no clearing.
// When the receiver stalls, the output register holds its word; the block
// takes no tokens and halts while a popped operator waits for the output.
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH  = 16,
   parameter int OPERAND_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   itp_req_if.sink    req_chan,
   itp_rsp_if.source  rsp_chan
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    discard_ff, discard_in;
   logic                    ovf_ff, ovf_in;
   logic [2:0]              tok_op_ff, tok_op_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [2:0]              pend_op_ff, pend_op_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [2:0]              rsp_op_ff, rsp_op_in;
   logic [OPERAND_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [2:0]    wr_data;
   logic [CW-1:0] rd_ptr;
   logic [AW-1:0] rd_addr;
   logic [2:0]    top;

   logic out_free, accept, has_top, top_marker, pop_oper, done, stall;
   logic push_req;
   logic [2:0] push_code;

   itp_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (top)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign has_top    = count_ff != '0;
   assign top_marker = top == OP_MARKER;
   assign pop_oper   = has_top && !top_marker && (op_prec(top) >= op_prec(tok_op_ff));

   always_comb begin
      case (state_ff)
         ST_OPER:  done = !pop_oper;
         ST_CLOSE: done = !(has_top && !top_marker);
         ST_END:   done = !has_top && !pend_valid_ff;
         default:  done = 1'b0;
      endcase
   end

   assign stall = (pend_valid_ff || (state_ff == ST_END && done)) && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.func == FUNC_END) begin
                  state_in = ST_END;
               end else if (!discard_ff) begin
                  case (req_chan.func)
                     FUNC_OPERATOR: begin
                        if (req_chan.op_code <= OP_SUB) begin
                           state_in = ST_OPER;
                        end
                     end
                     FUNC_CLOSE: state_in = ST_CLOSE;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_OPER, ST_CLOSE, ST_END: begin
            if (!stall && done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and stack access
   always_comb begin
      count_in      = count_ff;
      discard_in    = discard_ff;
      ovf_in        = ovf_ff;
      tok_op_in     = tok_op_ff;
      pend_valid_in = pend_valid_ff;
      pend_op_in    = pend_op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      push_req      = 1'b0;
      push_code     = OP_MARKER;
      wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !discard_ff) begin
               case (req_chan.func)
                  FUNC_OPERAND: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_OPERAND;
                     rsp_op_in    = '0;
                     rsp_value_in = req_chan.operand_value;
                     rsp_ovf_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                  end
                  FUNC_OPERATOR: tok_op_in = req_chan.op_code;
                  FUNC_OPEN: push_req = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_OPER, ST_CLOSE, ST_END: begin
            if (!stall) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_OPERATOR;
                  rsp_op_in     = pend_op_ff;
                  rsp_value_in  = '0;
                  rsp_ovf_in    = 1'b0;
                  rsp_last_in   = done && (state_ff != ST_END);
                  pend_valid_in = 1'b0;
               end
               case (state_ff)
                  ST_OPER: begin
                     if (pop_oper) begin
                        pend_valid_in = 1'b1;
                        pend_op_in    = top;
                        count_in      = count_ff - CW'(1);
                     end else begin
                        push_req  = 1'b1;
                        push_code = tok_op_ff;
                     end
                  end
                  ST_CLOSE: begin
                     if (has_top) begin
                        count_in = count_ff - CW'(1);
                        if (!top_marker) begin
                           pend_valid_in = 1'b1;
                           pend_op_in    = top;
                        end
                     end else begin
                        discard_in = 1'b1;
                     end
                  end
                  default: begin
                     if (has_top) begin
                        count_in = count_ff - CW'(1);
                        if (!top_marker) begin
                           pend_valid_in = 1'b1;
                           pend_op_in    = top;
                        end
                     end else if (!pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_END;
                        rsp_op_in    = '0;
                        rsp_value_in = '0;
                        rsp_ovf_in   = ovf_ff;
                        rsp_last_in  = 1'b1;
                        ovf_in       = 1'b0;
                        discard_in   = 1'b0;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      if (push_req) begin
         if (count_ff == CW'(STACK_DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end
   end

   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = push_code;
   assign rd_ptr  = count_in - CW'(1);
   assign rd_addr = rd_ptr[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         discard_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         discard_ff    <= discard_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_op_ff    <= tok_op_in;
      pend_op_ff   <= pend_op_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_kind   = rsp_kind_ff;
   assign rsp_chan.out_op     = rsp_op_ff;
   assign rsp_chan.out_value  = rsp_value_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;
   assign rsp_chan.last       = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff < CW'(STACK_DEPTH))
      else $error("stack write while full");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("popped operator left pending in idle");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && state_in == ST_IDLE)
         |=> (count_ff == '0 && !discard_ff && !ovf_ff))
      else $error("end of expression left state behind");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_END) |-> (rsp_last_ff && state_ff == ST_IDLE))
      else $error("end word not last or block still busy");

endmodule
